[src/kab_pkg.sv]
package kab_pkg;

   // Default fraction bits of covariance, noise, dt and gain values
   localparam int KAB_COV_FRAC_BITS = 28;

   // Operand widths of the shared multiply unit
   localparam int KAB_A_W   = 35;
   localparam int KAB_B_W   = 33;
   localparam int KAB_ACC_W = KAB_A_W + KAB_B_W;

   // Width of the gain denominator R + P00
   localparam int KAB_DEN_W = 34;

   // Configuration register indexes
   localparam logic [1:0] CSR_Q_ANGLE = 2'd0;
   localparam logic [1:0] CSR_Q_BIAS  = 2'd1;
   localparam logic [1:0] CSR_R_MEAS  = 2'd2;
   localparam logic [1:0] CSR_DT      = 2'd3;

   // Multiply unit control
   typedef struct packed {
      logic lo;
      logic hi;
      logic sub;
   } mac_ctrl_type;

   // Divider states
   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_DONE
   } div_state_type;

   // Sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LO,
      PH_HI,
      PH_WB,
      PH_K0_GO,
      PH_K0_WAIT,
      PH_K1_GO,
      PH_K1_WAIT
   } phase_type;

   // Multiply operations, in issue order; bias is corrected before the
   // angle so that both corrections see the innovation of the predicted angle
   typedef enum logic [3:0] {
      OP_ANGLE_PRED,
      OP_C00_PRED,
      OP_C01_PRED,
      OP_C10_PRED,
      OP_C11_PRED,
      OP_C10_CORR,
      OP_C11_CORR,
      OP_C00_CORR,
      OP_C01_CORR,
      OP_BIAS_CORR,
      OP_ANGLE_CORR
   } op_type;

endpackage

[src/kalman_angle_bias_filter.sv]
// Two-state Kalman filter for tilt angle and gyro bias. Each req item carries
// a measured angle and a gyro rate in signed Q16.16; each rsp item returns the
// corrected angle and bias in signed Q16.16. Covariance, noise terms, dt and
// gains are Q4.28 (COV_FRAC_BITS) and every stored value saturates to 32 bits.
// One shared multiply unit handles eleven products, each in phases LO, HI and
// WB, and one restoring divider forms both gains; req_tready is low from accept
// to result.
// A finished result waits in the rsp register while the next item is taken.
// Configuration writes on the csr port are accepted whenever reset is low and
// must be made while no item is in flight.
module kalman_angle_bias_filter #(
   parameter int COV_FRAC_BITS = kab_pkg::KAB_COV_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] angle_meas, [63:32] gyro_rate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] angle_est, [63:32] bias_est
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import kab_pkg::*;

   localparam logic [31:0] ONE_Q      = 32'(64'd1 << COV_FRAC_BITS);
   localparam logic [31:0] Q_RESET    = 32'((64'd1 << COV_FRAC_BITS) / 64'd1000);
   localparam logic [31:0] R_RESET    = 32'(64'd5 << COV_FRAC_BITS);
   localparam logic [31:0] DT_RESET   = 32'((64'd5 << COV_FRAC_BITS) / 64'd1000);

   phase_type          phase_ff, phase_in;
   op_type             op_ff, op_in;
   logic [31:0]        q_angle_ff, q_bias_ff, r_meas_ff, dt_ff;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] c00_ff, c00_in, c01_ff, c01_in;
   logic signed [31:0] c10_ff, c10_in, c11_ff, c11_in;
   logic signed [31:0] meas_ff, meas_in, rate_ff, rate_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   mac_ctrl_type               mac_ctrl;
   logic signed [KAB_A_W-1:0]  mac_a;
   logic signed [KAB_B_W-1:0]  mac_b;
   logic signed [31:0]         mac_base;
   logic signed [31:0]         mac_result;
   logic                       div_start;
   logic                       div_done;
   logic signed [31:0]         div_num;
   logic signed [31:0]         div_quot;
   logic signed [KAB_DEN_W-1:0] den;
   logic signed [KAB_A_W-1:0]  err;
   logic signed [KAB_B_W-1:0]  dt_op;
   logic                       accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (phase_ff == PH_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = !reset;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff <= Q_RESET;
         q_bias_ff  <= Q_RESET;
         r_meas_ff  <= R_RESET;
         dt_ff      <= DT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_Q_ANGLE: q_angle_ff <= csr_data;
            CSR_Q_BIAS:  q_bias_ff  <= csr_data;
            CSR_R_MEAS:  r_meas_ff  <= csr_data;
            CSR_DT:      dt_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Shared operands
   assign dt_op   = $signed({1'b0, dt_ff});
   assign err     = KAB_A_W'(meas_ff) - KAB_A_W'(angle_ff);
   assign den     = KAB_DEN_W'($signed({1'b0, r_meas_ff})) + KAB_DEN_W'(c00_ff);
   assign div_num = (phase_ff == PH_K1_GO) ? c10_ff : c00_ff;

   // Route operands and control of the current multiply
   always_comb begin
      mac_a        = KAB_A_W'(c00_ff);
      mac_b        = dt_op;
      mac_base     = c00_ff;
      mac_ctrl.lo  = (phase_ff == PH_LO);
      mac_ctrl.hi  = (phase_ff == PH_HI);
      mac_ctrl.sub = 1'b0;
      case (op_ff)
         OP_ANGLE_PRED: begin
            mac_a    = KAB_A_W'(rate_ff) - KAB_A_W'(bias_ff);
            mac_base = angle_ff;
         end
         OP_C00_PRED: begin
            mac_a = KAB_A_W'($signed({1'b0, q_angle_ff})) - KAB_A_W'(c01_ff)
                    - KAB_A_W'(c10_ff);
         end
         OP_C01_PRED: begin
            mac_a    = KAB_A_W'(0) - KAB_A_W'(c11_ff);
            mac_base = c01_ff;
         end
         OP_C10_PRED: begin
            mac_a    = KAB_A_W'(0) - KAB_A_W'(c11_ff);
            mac_base = c10_ff;
         end
         OP_C11_PRED: begin
            mac_a    = KAB_A_W'($signed({1'b0, q_bias_ff}));
            mac_base = c11_ff;
         end
         OP_C10_CORR: begin
            mac_b        = KAB_B_W'(k1_ff);
            mac_base     = c10_ff;
            mac_ctrl.sub = 1'b1;
         end
         OP_C11_CORR: begin
            mac_a        = KAB_A_W'(c01_ff);
            mac_b        = KAB_B_W'(k1_ff);
            mac_base     = c11_ff;
            mac_ctrl.sub = 1'b1;
         end
         OP_C00_CORR: begin
            mac_b        = KAB_B_W'(k0_ff);
            mac_ctrl.sub = 1'b1;
         end
         OP_C01_CORR: begin
            mac_a        = KAB_A_W'(c01_ff);
            mac_b        = KAB_B_W'(k0_ff);
            mac_base     = c01_ff;
            mac_ctrl.sub = 1'b1;
         end
         OP_ANGLE_CORR: begin
            mac_a    = err;
            mac_b    = KAB_B_W'(k0_ff);
            mac_base = angle_ff;
         end
         OP_BIAS_CORR: begin
            mac_a    = err;
            mac_b    = KAB_B_W'(k1_ff);
            mac_base = bias_ff;
         end
         default: ;
      endcase
   end

   // Sequencer: next phase, writeback and result hand-off
   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      c00_in       = c00_ff;
      c01_in       = c01_ff;
      c10_in       = c10_ff;
      c11_in       = c11_ff;
      meas_in      = meas_ff;
      rate_in      = rate_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_start    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               meas_in  = $signed(req_tdata[31:0]);
               rate_in  = $signed(req_tdata[63:32]);
               op_in    = OP_ANGLE_PRED;
               phase_in = PH_LO;
            end
         end
         PH_LO: begin
            phase_in = PH_HI;
         end
         PH_HI: begin
            phase_in = PH_WB;
         end
         PH_WB: begin
            case (op_ff)
               OP_ANGLE_PRED, OP_ANGLE_CORR: angle_in = mac_result;
               OP_C00_PRED, OP_C00_CORR:     c00_in   = mac_result;
               OP_C01_PRED, OP_C01_CORR:     c01_in   = mac_result;
               OP_C10_PRED, OP_C10_CORR:     c10_in   = mac_result;
               OP_C11_PRED, OP_C11_CORR:     c11_in   = mac_result;
               OP_BIAS_CORR:                 bias_in  = mac_result;
               default: ;
            endcase
            if (op_ff == OP_ANGLE_CORR) begin
               // hold until the rsp register is free
               if (rsp_valid_ff && !rsp_tready) begin
                  angle_in = angle_ff;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {bias_ff, mac_result};
                  phase_in     = PH_IDLE;
               end
            end else if (op_ff == OP_C11_PRED) begin
               phase_in = PH_K0_GO;
            end else begin
               op_in    = op_type'(4'(op_ff) + 4'd1);
               phase_in = PH_LO;
            end
         end
         PH_K0_GO: begin
            div_start = 1'b1;
            phase_in  = PH_K0_WAIT;
         end
         PH_K0_WAIT: begin
            if (div_done) begin
               k0_in    = div_quot;
               phase_in = PH_K1_GO;
            end
         end
         PH_K1_GO: begin
            div_start = 1'b1;
            phase_in  = PH_K1_WAIT;
         end
         PH_K1_WAIT: begin
            if (div_done) begin
               k1_in    = div_quot;
               op_in    = OP_C10_CORR;
               phase_in = PH_LO;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         op_ff        <= OP_ANGLE_PRED;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         c00_ff       <= $signed(ONE_Q);
         c01_ff       <= '0;
         c10_ff       <= '0;
         c11_ff       <= $signed(ONE_Q);
      end else begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         c00_ff       <= c00_in;
         c01_ff       <= c01_in;
         c10_ff       <= c10_in;
         c11_ff       <= c11_in;
      end
      meas_ff     <= meas_in;
      rate_ff     <= rate_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      rsp_data_ff <= rsp_data_in;
   end

   kab_mac #(
      .COV_FRAC_BITS (COV_FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .a_in   (mac_a),
      .b_in   (mac_b),
      .base   (mac_base),
      .result (mac_result)
   );

   kab_div #(
      .COV_FRAC_BITS (COV_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule

[src/kab_mac.sv]
module kab_mac #(
   parameter int COV_FRAC_BITS = kab_pkg::KAB_COV_FRAC_BITS
) (
   input  logic                               clock,
   input  kab_pkg::mac_ctrl_type              ctrl,
   input  logic signed [kab_pkg::KAB_A_W-1:0] a_in,
   input  logic signed [kab_pkg::KAB_B_W-1:0] b_in,
   input  logic signed [31:0]                 base,
   output logic signed [31:0]                 result
);
   import kab_pkg::*;

   localparam int PP_W  = KAB_A_W + 17;
   localparam int SUM_W = KAB_ACC_W + 1;

   logic signed [PP_W-1:0]      prod_lo;
   logic signed [PP_W-1:0]      prod_hi;
   logic signed [KAB_ACC_W-1:0] acc_ff;
   logic signed [KAB_ACC_W-1:0] acc_in;
   logic signed [KAB_ACC_W-1:0] shifted;
   logic signed [SUM_W-1:0]     base_ext;
   logic signed [SUM_W-1:0]     term;
   logic signed [SUM_W-1:0]     sum;

   // Partial products over the low and high halves of b
   assign prod_lo = a_in * $signed({1'b0, b_in[15:0]});
   assign prod_hi = a_in * $signed(b_in[KAB_B_W-1:16]);

   // Accumulate low half first, then the shifted high half
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.lo) begin
         acc_in = KAB_ACC_W'(prod_lo);
      end else if (ctrl.hi) begin
         acc_in = acc_ff + (KAB_ACC_W'(prod_hi) <<< 16);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Floor shift, add or subtract against base, saturate to 32 bits
   assign shifted  = acc_ff >>> COV_FRAC_BITS;
   assign base_ext = SUM_W'(base);
   assign term     = SUM_W'(shifted);
   assign sum      = ctrl.sub ? (base_ext - term) : (base_ext + term);

   always_comb begin
      if (sum[SUM_W-1] && !(&sum[SUM_W-2:31])) begin
         result = 32'sh8000_0000;
      end else if (!sum[SUM_W-1] && (|sum[SUM_W-2:31])) begin
         result = 32'sh7fff_ffff;
      end else begin
         result = sum[31:0];
      end
   end

endmodule

[src/kab_div.sv]
module kab_div #(
   parameter int COV_FRAC_BITS = kab_pkg::KAB_COV_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [31:0]                   num,
   input  logic signed [kab_pkg::KAB_DEN_W-1:0] den,
   output logic                                 done,
   output logic signed [31:0]                   quot
);
   import kab_pkg::*;

   localparam int NUM_W = 33 + COV_FRAC_BITS;

   div_state_type          state_ff, state_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [KAB_DEN_W-1:0]   rem_ff, rem_in;
   logic [KAB_DEN_W-1:0]   dv_ff, dv_in;
   logic [31:0]            lo_ff, lo_in;
   logic [31:0]            q_ff, q_in;
   logic                   neg_ff, neg_in;
   logic [32:0]            mag_p;
   logic [KAB_DEN_W-1:0]   mag_d;
   logic [NUM_W-1:0]       mag_n;
   logic [KAB_DEN_W-1:0]   num_hi;
   logic [KAB_DEN_W:0]     trial;

   // Magnitudes of the scaled numerator and of the denominator
   assign mag_p  = num[31] ? (33'd0 - 33'($signed(num))) : 33'(num);
   assign mag_d  = den[KAB_DEN_W-1] ? (KAB_DEN_W'(0) - den) : den;
   assign mag_n  = NUM_W'(mag_p) << COV_FRAC_BITS;
   assign num_hi = KAB_DEN_W'(mag_n >> 32);
   assign trial  = {rem_ff, lo_ff[31]};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      lo_in    = lo_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      done     = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               neg_in = num[31] ^ den[KAB_DEN_W-1];
               dv_in  = mag_d;
               rem_in = num_hi;
               lo_in  = mag_n[31:0];
               q_in   = '0;
               cnt_in = '0;
               if (den == '0) begin
                  // no gain for a zero denominator
                  state_in = DV_DONE;
               end else if (num_hi >= mag_d) begin
                  // quotient needs more than 32 bits: saturate
                  q_in     = '1;
                  state_in = DV_DONE;
               end else begin
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            // one restoring step per cycle
            if (trial >= {1'b0, dv_ff}) begin
               rem_in = KAB_DEN_W'(trial - {1'b0, dv_ff});
               q_in   = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = KAB_DEN_W'(trial);
               q_in   = {q_ff[30:0], 1'b0};
            end
            lo_in  = {lo_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            done     = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // Apply sign and saturate the truncated quotient
   always_comb begin
      if (!neg_ff) begin
         quot = q_ff[31] ? 32'sh7fff_ffff : $signed(q_ff);
      end else if (q_ff > 32'h8000_0000) begin
         quot = 32'sh8000_0000;
      end else begin
         quot = $signed(32'd0 - q_ff);
      end
   end

endmodule

[src/kab_checker.sv]
module kab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // The block is busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after accept");

   // A new result only appears at the end of a busy stretch
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without work");

   // Configuration is written only while no item is in flight
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_tready)
      else $error("csr write while an item is in flight");

endmodule

bind kalman_angle_bias_filter kab_checker u_kab_checker (.*);
